// File: design/lb64_pkg.sv
// Package for the lenient base64url decoder: character constants and digit mapping.
`timescale 1ns / 1ps
package lb64_pkg;

   localparam int CHAR_W    = 8;
   localparam int DIGIT_W   = 6;
   localparam int ACC_W     = 12;
   localparam int PENDING_W = 3;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_UNDER   = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_PAD     = 8'h3D;

   localparam logic [DIGIT_W-1:0] DIGIT_LOWER_BASE = 6'd26;
   localparam logic [DIGIT_W-1:0] DIGIT_NUM_BASE   = 6'd52;
   localparam logic [DIGIT_W-1:0] DIGIT_62         = 6'd62;
   localparam logic [DIGIT_W-1:0] DIGIT_63         = 6'd63;

   typedef struct packed {
      logic                 valid;
      logic [DIGIT_W-1:0]   value;
   } digit_type;

   // Maps one character to its 6-bit digit; valid is low for skipped characters.
   function automatic digit_type digit_of(input logic [CHAR_W-1:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.value = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d.value = DIGIT_W'(c - CHAR_UPPER_A);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d.value = DIGIT_W'(c - CHAR_LOWER_A) + DIGIT_LOWER_BASE;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d.value = DIGIT_W'(c - CHAR_ZERO) + DIGIT_NUM_BASE;
      end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
         d.value = DIGIT_62;
      end else if (c == CHAR_UNDER || c == CHAR_SLASH) begin
         d.value = DIGIT_63;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

// File: design/lenient_base64url_decoder_core.sv
// Top level of the lenient base64url decoder: one character in, at most one byte out.
//
// Usage: each req_ beat carries one raw character (req_char_code) and a flag
// (req_string_end) that marks the last character of a string. URL-safe base64
// letters plus '+' and '/' are decoded, other characters are skipped, and an '='
// stops decoding until the end of the string. A rsp_ beat is produced when a byte
// completes (rsp_byte_valid high) or on the last character of a string
// (rsp_frame_end high); characters that complete nothing produce no beat.
// Results are registered: a character accepted in one cycle shows its result on the
// rsp_ ports in the next. Throughput is one character per clock while results are
// taken, set by the single result register; the decode and accumulator update are
// combinational. A new character is taken while a result waits, as long as the
// receiver takes that result in the same cycle; if rsp_ready stays low with a result
// held, req_ready drops and the input stalls without losing anything.
// Reset (synchronous, active high) clears the accumulator, the bit count, the
// padding flag and the result valid flag; the held result fields are not reset. The
// last character of each string clears the decoding state, so leftover bits are dropped.
`timescale 1ns / 1ps
module lenient_base64url_decoder_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lb64_pkg::CHAR_W-1:0]    req_char_code,
   input  logic                           req_string_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lb64_pkg::CHAR_W-1:0]    rsp_data_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_frame_end
);
   import lb64_pkg::*;

   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [PENDING_W-1:0] pending_ff, pending_in;
   logic                 stopped_ff, stopped_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    data_ff, data_in;
   logic                 byte_valid_ff, byte_valid_in;
   logic                 frame_end_ff, frame_end_in;

   logic                 accept;
   digit_type            digit;
   logic [ACC_W-1:0]     acc_shifted;
   logic [PENDING_W-1:0] shift_amt;
   logic                 have_byte;
   logic [CHAR_W-1:0]    byte_val;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign digit     = digit_of(req_char_code);

   assign acc_shifted = {acc_ff[ACC_W-DIGIT_W-1:0], digit.value};
   // With 2, 4 or 6 bits pending, the new byte sits 0, 2 or 4 bits above the bottom.
   assign shift_amt   = pending_ff - PENDING_W'(2);
   assign byte_val    = CHAR_W'(acc_shifted >> shift_amt);

   always_comb begin
      acc_in        = acc_ff;
      pending_in    = pending_ff;
      stopped_in    = stopped_ff;
      have_byte     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      data_in       = data_ff;
      byte_valid_in = byte_valid_ff;
      frame_end_in  = frame_end_ff;
      if (accept) begin
         if (!stopped_ff) begin
            if (req_char_code == CHAR_PAD) begin
               stopped_in = 1'b1;
            end else if (digit.valid) begin
               acc_in = acc_shifted;
               if (pending_ff != '0) begin
                  have_byte  = 1'b1;
                  pending_in = pending_ff - PENDING_W'(2);
               end else begin
                  pending_in = PENDING_W'(DIGIT_W);
               end
            end
         end
         if (req_string_end) begin
            acc_in     = '0;
            pending_in = '0;
            stopped_in = 1'b0;
         end
         if (have_byte || req_string_end) begin
            rsp_valid_in  = 1'b1;
            data_in       = have_byte ? byte_val : '0;
            byte_valid_in = have_byte;
            frame_end_in  = req_string_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pending_ff   <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         pending_ff   <= pending_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      byte_valid_ff <= byte_valid_in;
      frame_end_ff  <= frame_end_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_frame_end  = frame_end_ff;

endmodule
